// File: design/frac_pkg.sv
// Package: command and status types shared by the fraction reducer controller and datapath.
`timescale 1ns / 1ps

package frac_pkg;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;           // capture request, form magnitudes
      logic gcd_step;       // one binary GCD step
      logic gcd_finish;     // form gcd, start numerator division
      logic div_step;       // one restoring division step
      logic div_reload_den; // save numerator quotient, start denominator division
      logic emit;           // present reduced result
      logic emit_error;     // present pass-through result with error flag
   } ctrl_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic den_zero;
      logic a_zero;
      logic div_last;
   } ctrl_status_type;

endpackage

// File: design/frac_ctrl.sv
// Controller: sequences load, GCD, the two divisions and result output.
`timescale 1ns / 1ps

module frac_ctrl
   import frac_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  ctrl_status_type status,
   output ctrl_cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_GCD  = 3'd1;
   localparam logic [2:0] ST_DIVN = 3'd2;
   localparam logic [2:0] ST_DIVD = 3'd3;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_GCD;
            end
         end
         ST_GCD: begin
            if (status.den_zero) begin
               cmd.emit_error = 1'b1;
               state_in       = ST_IDLE;
            end else if (status.a_zero) begin
               cmd.gcd_finish = 1'b1;
               state_in       = ST_DIVN;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         ST_DIVN: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               cmd.div_reload_den = 1'b1;
               state_in           = ST_DIVD;
            end
         end
         ST_DIVD: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // at most one of load, gcd_step, gcd_finish, div_step and emit_error at a time
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.gcd_step, cmd.gcd_finish, cmd.div_step, cmd.emit_error}))
      else $error("frac_ctrl: conflicting commands");

   // a zero denominator never reaches the divider
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit_error |=> !busy)
      else $error("frac_ctrl: error result did not end the request");

   // division phases end in the expected order
   assert property (@(posedge clock) disable iff (reset)
      cmd.div_reload_den |=> (state_ff == ST_DIVD))
      else $error("frac_ctrl: denominator division not started");

endmodule

// File: design/frac_dpath.sv
// Datapath: magnitudes, binary GCD unit, shared serial divider, sign restore and output register.
`timescale 1ns / 1ps

module frac_dpath
   import frac_pkg::*;
#(
   parameter int DATA_WIDTH = 32
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  ctrl_cmd_type          cmd,
   output ctrl_status_type       status,
   input  logic [DATA_WIDTH-1:0] req_numerator_in,
   input  logic [DATA_WIDTH-1:0] req_denominator_in,
   output logic                  rsp_valid,
   output logic [DATA_WIDTH-1:0] rsp_numerator_out,
   output logic [DATA_WIDTH-1:0] rsp_denominator_out,
   output logic                  rsp_divide_error
);

   localparam int W  = DATA_WIDTH;
   localparam int KW = $clog2(DATA_WIDTH);

   logic [W-1:0]  num_ff, den_ff;       // original parts (sign, pass-through)
   logic [W-1:0]  na_ff, da_ff;         // magnitudes
   logic [W-1:0]  a_ff, b_ff, a_in, b_in;
   logic [KW-1:0] k_ff, k_in;           // common power of two
   logic [W-1:0]  g_ff;
   logic [W-1:0]  q_ff, r_ff, qn_ff;
   logic [KW-1:0] cnt_ff;

   logic [W-1:0]  na_mag, da_mag;
   logic [W-1:0]  diff_ab, diff_ba;
   logic [W:0]    shifted, trial;
   logic [W-1:0]  r_next, q_next;
   logic          qbit;

   logic          valid_ff;
   logic [W-1:0]  num_out_ff, den_out_ff;
   logic          err_ff;

   assign na_mag = req_numerator_in[W-1]   ? (~req_numerator_in + 1'b1)   : req_numerator_in;
   assign da_mag = req_denominator_in[W-1] ? (~req_denominator_in + 1'b1) : req_denominator_in;

   // binary GCD step
   assign diff_ab = a_ff - b_ff;
   assign diff_ba = b_ff - a_ff;

   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      k_in = k_ff;
      if (!a_ff[0] && !b_ff[0]) begin
         a_in = a_ff >> 1;
         b_in = b_ff >> 1;
         k_in = k_ff + 1'b1;
      end else if (!a_ff[0]) begin
         a_in = a_ff >> 1;
      end else if (!b_ff[0]) begin
         b_in = b_ff >> 1;
      end else if (a_ff >= b_ff) begin
         a_in = diff_ab >> 1;
      end else begin
         b_in = diff_ba >> 1;
      end
   end

   // restoring division step
   assign shifted = {r_ff, q_ff[W-1]};
   assign trial   = shifted - {1'b0, g_ff};
   assign qbit    = ~trial[W];
   assign r_next  = qbit ? trial[W-1:0] : shifted[W-1:0];
   assign q_next  = {q_ff[W-2:0], qbit};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         num_ff <= req_numerator_in;
         den_ff <= req_denominator_in;
         na_ff  <= na_mag;
         da_ff  <= da_mag;
         a_ff   <= na_mag;
         b_ff   <= da_mag;
         k_ff   <= '0;
      end
      if (cmd.gcd_step) begin
         a_ff <= a_in;
         b_ff <= b_in;
         k_ff <= k_in;
      end
      if (cmd.gcd_finish) begin
         g_ff   <= b_ff << k_ff;
         q_ff   <= na_ff;
         r_ff   <= '0;
         cnt_ff <= '0;
      end else if (cmd.div_reload_den) begin
         qn_ff  <= q_next;
         q_ff   <= da_ff;
         r_ff   <= '0;
         cnt_ff <= '0;
      end else if (cmd.div_step) begin
         q_ff   <= q_next;
         r_ff   <= r_next;
         cnt_ff <= cnt_ff + 1'b1;
      end
      if (cmd.emit) begin
         num_out_ff <= num_ff[W-1] ? (~qn_ff + 1'b1) : qn_ff;
         den_out_ff <= den_ff[W-1] ? (~q_next + 1'b1) : q_next;
         err_ff     <= 1'b0;
      end else if (cmd.emit_error) begin
         num_out_ff <= num_ff;
         den_out_ff <= den_ff;
         err_ff     <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= cmd.emit | cmd.emit_error;
      end
   end

   assign status.den_zero = (den_ff == '0);
   assign status.a_zero   = (a_ff == '0);
   assign status.div_last = (cnt_ff == KW'(W - 1));

   assign rsp_valid           = valid_ff;
   assign rsp_numerator_out   = num_out_ff;
   assign rsp_denominator_out = den_out_ff;
   assign rsp_divide_error    = err_ff;

   // b holds a nonzero value through the whole GCD
   assert property (@(posedge clock) disable iff (reset)
      cmd.gcd_step |-> (b_ff != '0))
      else $error("frac_dpath: GCD operand b reached zero");

   // remainder stays below the divisor
   assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |=> (r_ff < g_ff) || $past(cmd.div_reload_den))
      else $error("frac_dpath: division remainder out of range");

   // a good result has a nonzero denominator, an error result a zero one
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_denominator_out == '0) == rsp_divide_error))
      else $error("frac_dpath: denominator and error flag disagree");

endmodule

// File: design/fraction_reduce.sv
// Top level: fraction reducer, reduces a signed fraction to lowest terms.
`timescale 1ns / 1ps

// Usage
//   Request channel: drive req_numerator_in and req_denominator_in (two's
//   complement) and raise start; the request is taken at the clock edge where
//   start is high and busy is low. busy stays high while the request is worked.
//   Response channel: rsp_valid is high for exactly one cycle with the reduced
//   parts on rsp_numerator_out / rsp_denominator_out. Each part keeps its own
//   sign. A zero denominator gives rsp_divide_error = 1 and the input parts
//   unchanged; a zero numerator gives 0 over +1 or -1.
//   Method: binary GCD, one step per cycle and at most 2*DATA_WIDTH-1 steps,
//   then one shared restoring divider for the numerator part and then the
//   denominator part; a zero denominator skips GCD and division. One request
//   at a time: the next is taken at the edge ending the strobe cycle, and how
//   long a request takes is set by the number of GCD steps.
//   The receiver cannot stall: a response must be taken in its strobe cycle.
//   Reset (synchronous, active high) returns the controller to idle and drops
//   any request in flight; no response is produced for it.

module fraction_reduce
   import frac_pkg::*;
#(
   parameter int DATA_WIDTH = 32
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [DATA_WIDTH-1:0] req_numerator_in,
   input  logic [DATA_WIDTH-1:0] req_denominator_in,
   output logic                  rsp_valid,
   output logic [DATA_WIDTH-1:0] rsp_numerator_out,
   output logic [DATA_WIDTH-1:0] rsp_denominator_out,
   output logic                  rsp_divide_error
);

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   // sequencer: idle -> gcd -> numerator divide -> denominator divide -> idle, or gcd -> idle on a zero denominator
   frac_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   // arithmetic and result register
   frac_dpath #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_numerator_in    (req_numerator_in),
      .req_denominator_in  (req_denominator_in),
      .rsp_valid           (rsp_valid),
      .rsp_numerator_out   (rsp_numerator_out),
      .rsp_denominator_out (rsp_denominator_out),
      .rsp_divide_error    (rsp_divide_error)
   );

   // a taken request makes the block busy
   assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("fraction_reduce: request taken but not busy");

   // a response arrives only once the request is finished
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("fraction_reduce: response while still busy");

   // one strobe per request
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("fraction_reduce: repeated response strobe");

endmodule
